// File: rtl/rpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpa_pkg
// Shared types and codes for the reference-counted page allocator.
// ----------------------------------------------------------------------------
package rpa_pkg;

  // operation codes
  localparam logic [1:0] FN_ALLOC = 2'd0;
  localparam logic [1:0] FN_FREE  = 2'd1;
  localparam logic [1:0] FN_SHARE = 2'd2;
  localparam logic [1:0] FN_INIT  = 2'd3;

  // result status codes
  localparam logic [2:0] ST_ALLOCATED = 3'd0;
  localparam logic [2:0] ST_RETURNED  = 3'd1;
  localparam logic [2:0] ST_SHARED    = 3'd2;
  localparam logic [2:0] ST_NO_MEM    = 3'd3;
  localparam logic [2:0] ST_BAD_ADDR  = 3'd4;
  localparam logic [2:0] ST_CNT_ERR   = 3'd5;
  localparam logic [2:0] ST_INIT_DONE = 3'd6;

  // configuration register indexes
  localparam logic REG_BASE = 1'b0;
  localparam logic REG_TOP  = 1'b1;

  localparam int BASE_W = 20;
  localparam int TOP_W  = 21;
  localparam int CFG_W  = 21;
  // page-number arithmetic width: holds a page of a 32-bit address at the
  // smallest page size and base plus pool size at the largest pool
  localparam int PG_W   = 27;

  localparam logic [BASE_W-1:0] BASE_RST = 20'd524288;
  localparam logic [TOP_W-1:0]  TOP_RST  = 21'd557056;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] address;
  } req_t;

  typedef struct packed {
    logic [31:0] page_address;
    logic [2:0]  status;
  } res_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic sweep;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sweep_last;
  } sts_t;

endpackage

// File: rtl/rpa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpa_ctrl
// Sequencer: takes a request, runs the execute state or the init sweep.
// ----------------------------------------------------------------------------
module rpa_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [1:0]    in_func,
  input  rpa_pkg::sts_t sts,
  output rpa_pkg::cmd_t cmd,
  output logic          busy
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_SWEEP = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    cmd.sweep   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          if (in_func == rpa_pkg::FN_INIT) begin
            state_nxt = S_SWEEP;
          end else begin
            state_nxt = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_IDLE;
      end
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  // an execute cycle always follows a non-init request directly
  a_exec_follows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture && in_func != rpa_pkg::FN_INIT |=> cmd.exec)
    else $error("execute cycle did not follow request");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.capture, cmd.exec, cmd.sweep}))
    else $error("conflicting datapath commands");

  a_sweep_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sweep && !sts.sweep_last |=> cmd.sweep && busy)
    else $error("init sweep ended early");

endmodule

// File: rtl/rpa_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpa_dpath
// Free stack and count memories, stack pointer, config and result registers.
// ----------------------------------------------------------------------------
module rpa_dpath #(
  parameter int MAX_PAGES  = 32768,
  parameter int PAGE_SHIFT = 12,
  parameter int COUNT_BITS = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  rpa_pkg::req_t            in_req,
  input  rpa_pkg::cmd_t            cmd,
  output rpa_pkg::sts_t            sts,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [rpa_pkg::CFG_W-1:0] cfg_wdata,
  output logic                     out_strobe,
  output rpa_pkg::res_t            out_res
);

  localparam int IDX_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int SC_W  = $clog2(MAX_PAGES + 1);
  localparam int PG_W  = rpa_pkg::PG_W;

  // memories
  logic [IDX_W-1:0]      stack_mem [MAX_PAGES];
  logic [COUNT_BITS-1:0] count_mem [MAX_PAGES];

  logic [IDX_W-1:0]      stk_rd_r;
  logic [COUNT_BITS-1:0] cnt_rd_r;

  logic                  stk_we;
  logic [IDX_W-1:0]      stk_wa;
  logic [IDX_W-1:0]      stk_wd;
  logic                  cnt_we;
  logic [IDX_W-1:0]      cnt_wa;
  logic [COUNT_BITS-1:0] cnt_wd;

  // state and request registers
  logic [rpa_pkg::BASE_W-1:0] base_r;
  logic [rpa_pkg::TOP_W-1:0]  top_r;
  logic [SC_W-1:0]            sc_r;
  logic [SC_W-1:0]            sc_nxt;
  logic [1:0]                 func_r;
  logic [31:0]                addr_r;
  logic [IDX_W-1:0]           idx_r;
  logic [IDX_W-1:0]           clr_r;
  logic                       out_strobe_r;
  logic                       out_strobe_nxt;
  rpa_pkg::res_t              out_res_r;
  rpa_pkg::res_t              out_res_nxt;

  // address arithmetic
  logic [31:0]           sh_in;
  logic [PG_W-1:0]       pg_in;
  logic [PG_W-1:0]       idx_in;
  logic [31:0]           sh_q;
  logic [PG_W-1:0]       pg_q;
  logic [PG_W-1:0]       base_ext;
  logic [PG_W-1:0]       top_ext;
  logic [PG_W-1:0]       base_plus;
  logic [PG_W-1:0]       lim;
  logic [PG_W-1:0]       span;
  logic [SC_W-1:0]       pool_n;
  logic [SC_W-1:0]       sc_dec;
  logic                  addr_ok;
  logic [PG_W-1:0]       pop_pg;
  logic [63:0]           pop_wide;
  logic [COUNT_BITS-1:0] cnt_dec;
  logic                  stack_room;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

  assign base_ext  = PG_W'(base_r);
  assign top_ext   = PG_W'(top_r);
  assign base_plus = base_ext + PG_W'(MAX_PAGES);
  assign lim       = (top_ext < base_plus) ? top_ext : base_plus;
  assign span      = (lim > base_ext) ? (lim - base_ext) : '0;
  assign pool_n    = span[SC_W-1:0];

  assign sh_in  = in_req.address >> PAGE_SHIFT;
  assign pg_in  = sh_in[PG_W-1:0];
  assign idx_in = pg_in - base_ext;

  assign sh_q    = addr_r >> PAGE_SHIFT;
  assign pg_q    = sh_q[PG_W-1:0];
  assign addr_ok = (addr_r[PAGE_SHIFT-1:0] == '0) && (pg_q >= base_ext) && (pg_q < lim);

  assign sc_dec     = sc_r - SC_W'(1);
  assign stack_room = (sc_r < SC_W'(MAX_PAGES));
  assign pop_pg     = base_ext + PG_W'(stk_rd_r);
  assign pop_wide   = 64'(pop_pg) << PAGE_SHIFT;
  assign cnt_dec    = cnt_rd_r - CNT_ONE;

  assign sts.sweep_last = (clr_r == IDX_W'(MAX_PAGES - 1));

  always_comb begin
    sc_nxt         = sc_r;
    out_strobe_nxt = 1'b0;
    out_res_nxt    = out_res_r;
    stk_we         = 1'b0;
    stk_wa         = sc_r[IDX_W-1:0];
    stk_wd         = idx_r;
    cnt_we         = 1'b0;
    cnt_wa         = idx_r;
    cnt_wd         = cnt_dec;
    if (cmd.sweep) begin
      // clear one count and seed one stack slot per cycle
      stk_we = 1'b1;
      stk_wa = clr_r;
      stk_wd = clr_r;
      cnt_we = 1'b1;
      cnt_wa = clr_r;
      cnt_wd = '0;
      if (sts.sweep_last) begin
        sc_nxt                   = pool_n;
        out_strobe_nxt           = 1'b1;
        out_res_nxt.page_address = '0;
        out_res_nxt.status       = rpa_pkg::ST_INIT_DONE;
      end
    end else if (cmd.exec) begin
      out_strobe_nxt           = 1'b1;
      out_res_nxt.page_address = '0;
      case (func_r)
        rpa_pkg::FN_ALLOC: begin
          if (sc_r == '0) begin
            out_res_nxt.status = rpa_pkg::ST_NO_MEM;
          end else begin
            sc_nxt                   = sc_dec;
            cnt_we                   = 1'b1;
            cnt_wa                   = stk_rd_r;
            cnt_wd                   = CNT_ONE;
            out_res_nxt.page_address = pop_wide[31:0];
            out_res_nxt.status       = rpa_pkg::ST_ALLOCATED;
          end
        end
        rpa_pkg::FN_FREE: begin
          if (!addr_ok) begin
            out_res_nxt.status = rpa_pkg::ST_BAD_ADDR;
          end else if (cnt_rd_r == '0) begin
            out_res_nxt.status = rpa_pkg::ST_CNT_ERR;
          end else begin
            cnt_we = 1'b1;
            cnt_wd = cnt_dec;
            if (cnt_dec == '0) begin
              // last reference gone: page goes back on the stack if it has room
              if (stack_room) begin
                stk_we = 1'b1;
                sc_nxt = sc_r + SC_W'(1);
              end
              out_res_nxt.status = rpa_pkg::ST_RETURNED;
            end else begin
              out_res_nxt.status = rpa_pkg::ST_SHARED;
            end
          end
        end
        rpa_pkg::FN_SHARE: begin
          if (!addr_ok) begin
            out_res_nxt.status = rpa_pkg::ST_BAD_ADDR;
          end else if (cnt_rd_r == '0 || cnt_rd_r == CNT_MAX) begin
            out_res_nxt.status = rpa_pkg::ST_CNT_ERR;
          end else begin
            cnt_we             = 1'b1;
            cnt_wd             = cnt_rd_r + CNT_ONE;
            out_res_nxt.status = rpa_pkg::ST_SHARED;
          end
        end
        default: begin
          out_res_nxt.status = rpa_pkg::ST_INIT_DONE;
        end
      endcase
    end
  end

  // memory ports: one write and one registered read each
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack_mem[stk_wa] <= stk_wd;
    end
    if (cmd.capture) begin
      stk_rd_r <= stack_mem[sc_dec[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      count_mem[cnt_wa] <= cnt_wd;
    end
    if (cmd.capture) begin
      cnt_rd_r <= count_mem[idx_in[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= in_req.func;
      addr_r <= in_req.address;
      idx_r  <= idx_in[IDX_W-1:0];
    end
    if (cmd.capture) begin
      clr_r <= '0;
    end else if (cmd.sweep) begin
      clr_r <= clr_r + IDX_W'(1);
    end
    out_res_r <= out_res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r       <= rpa_pkg::BASE_RST;
      top_r        <= rpa_pkg::TOP_RST;
      sc_r         <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == rpa_pkg::REG_BASE) begin
        base_r <= cfg_wdata[rpa_pkg::BASE_W-1:0];
      end
      if (cfg_we && cfg_index == rpa_pkg::REG_TOP) begin
        top_r <= cfg_wdata[rpa_pkg::TOP_W-1:0];
      end
      sc_r         <= sc_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

  a_sc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sc_r <= SC_W'(MAX_PAGES))
    else $error("free stack pointer beyond pool size");

  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> $past(cmd.exec) || $past(cmd.sweep && sts.sweep_last))
    else $error("result strobe without finished request");

  a_alloc_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r && out_res_r.status == rpa_pkg::ST_ALLOCATED
      |-> sc_r == $past(sc_r) - SC_W'(1))
    else $error("allocation did not pop the free stack");

endmodule

// File: rtl/refcounted_page_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refcounted_page_allocator_core
// Page-frame allocator with a LIFO free stack and per-page reference counts.
// ----------------------------------------------------------------------------
// Alloc, free and add-reference requests: busy is high in the execute state
// that follows the cycle in which start is taken, and the result strobe comes
// in the cycle after that, when busy is low again, so a new request can be
// taken in the same cycle as the strobe. The execute state serves the
// read-modify-write on the count memory and the free stack, each with one
// registered read port and one write port. Init walks the whole count memory
// and free stack one entry per cycle and holds busy until its last entry is
// written. Results cannot be held off: out_strobe is high for exactly one
// cycle per request. A free or add-reference before the first init reads an unwritten count.
module refcounted_page_allocator_core #(
  parameter int MAX_PAGES  = 32768,
  parameter int PAGE_SHIFT = 12,
  parameter int COUNT_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  rpa_pkg::req_t             in_req,
  output logic                      out_strobe,
  output rpa_pkg::res_t             out_res,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [rpa_pkg::CFG_W-1:0] cfg_wdata
);

  rpa_pkg::cmd_t cmd;
  rpa_pkg::sts_t sts;

  rpa_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_func (in_req.func),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  rpa_dpath #(
    .MAX_PAGES  (MAX_PAGES),
    .PAGE_SHIFT (PAGE_SHIFT),
    .COUNT_BITS (COUNT_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_req     (in_req),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .out_strobe (out_strobe),
    .out_res    (out_res)
  );

endmodule

// File: tb/refcounted_page_allocator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refcounted_page_allocator_core_tb
// Self-checking bench for the page allocator: a queue-fed driver issues
// alloc, free, add-reference and init requests under random idle bursts, a
// predictor keeps its own free stack and count store to compute each result,
// and a monitor checks every strobed result against the oldest prediction.
// Pool ranges are reprogrammed between phases, from empty to one page to the
// widest settings, and one phase changes the base without a fresh init.
// ----------------------------------------------------------------------------
module refcounted_page_allocator_core_tb;

  localparam int POOL_PAGES  = 32768;
  localparam int PG_SHIFT    = 12;
  localparam int REF_BITS    = 8;
  localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};
  localparam int CYCLE_LIMIT = 2000000;
  localparam longint unsigned ADDR_PAGES = 64'd1 << (32 - PG_SHIFT);

  logic                      clk;
  logic                      rst_n     = 1'b0;
  logic                      start     = 1'b0;
  logic                      busy;
  rpa_pkg::req_t             in_req    = '0;
  logic                      out_strobe;
  rpa_pkg::res_t             out_res;
  logic                      cfg_we    = 1'b0;
  logic                      cfg_index = rpa_pkg::REG_BASE;
  logic [rpa_pkg::CFG_W-1:0] cfg_wdata = '0;

  refcounted_page_allocator_core #(
    .MAX_PAGES (POOL_PAGES),
    .PAGE_SHIFT(PG_SHIFT),
    .COUNT_BITS(REF_BITS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_strobe(out_strobe),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // predictor state
  logic [14:0]                free_pages [POOL_PAGES];
  logic [REF_BITS-1:0]        page_refs  [POOL_PAGES];
  int unsigned                free_depth = 0;
  logic [rpa_pkg::BASE_W-1:0] m_base;
  logic [rpa_pkg::TOP_W-1:0]  m_top;

  rpa_pkg::req_t req_q[$];
  rpa_pkg::res_t due_results[$];
  rpa_pkg::res_t want;
  int          errors    = 0;
  int          cycles    = 0;
  int          gap_left  = 0;
  bit          idle_en   = 1'b1;
  bit          req_taken = 1'b0;
  longint unsigned gen_base, gen_lim;

  function automatic rpa_pkg::res_t compute_page_result(rpa_pkg::req_t rq);
    rpa_pkg::res_t   r;
    longint unsigned base_l, lim, pg, n;
    int unsigned     idx;
    logic            addr_ok;
    r.page_address = '0;
    r.status       = rpa_pkg::ST_ALLOCATED;
    base_l = m_base;
    lim    = (longint'(m_top) < base_l + POOL_PAGES) ? m_top : base_l + POOL_PAGES;
    pg     = rq.address >> PG_SHIFT;
    addr_ok = (rq.address[PG_SHIFT-1:0] == '0) && (pg >= base_l) && (pg < lim);
    idx     = addr_ok ? int'(pg - base_l) : 0;
    case (rq.func)
      rpa_pkg::FN_ALLOC: begin
        if (free_depth == 0) begin
          r.status = rpa_pkg::ST_NO_MEM;
        end else begin
          free_depth--;
          idx = free_pages[free_depth];
          page_refs[idx] = 1;
          r.page_address = 32'((base_l + idx) << PG_SHIFT);
        end
      end
      rpa_pkg::FN_FREE: begin
        if (!addr_ok) begin
          r.status = rpa_pkg::ST_BAD_ADDR;
        end else if (page_refs[idx] == 0) begin
          r.status = rpa_pkg::ST_CNT_ERR;
        end else begin
          page_refs[idx] = page_refs[idx] - 1'b1;
          if (page_refs[idx] == 0) begin
            if (free_depth < POOL_PAGES) begin
              free_pages[free_depth] = idx[14:0];
              free_depth++;
            end
            r.status = rpa_pkg::ST_RETURNED;
          end else begin
            r.status = rpa_pkg::ST_SHARED;
          end
        end
      end
      rpa_pkg::FN_SHARE: begin
        if (!addr_ok) begin
          r.status = rpa_pkg::ST_BAD_ADDR;
        end else if (page_refs[idx] == 0 || page_refs[idx] == REF_MAX) begin
          r.status = rpa_pkg::ST_CNT_ERR;
        end else begin
          page_refs[idx] = page_refs[idx] + 1'b1;
          r.status = rpa_pkg::ST_SHARED;
        end
      end
      default: begin
        n = (lim > base_l) ? lim - base_l : 0;
        for (int i = 0; i < POOL_PAGES; i++) begin
          page_refs[i] = '0;
          if (i < n) free_pages[i] = 15'(i);
        end
        free_depth = int'(n);
        r.status = rpa_pkg::ST_INIT_DONE;
      end
    endcase
    return r;
  endfunction

  // request acceptance and register writes, seen at the rising edge
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timed out", $time);
      $display("status: fail");
      $finish;
    end else if (!rst_n) begin
      m_base     = rpa_pkg::BASE_RST;
      m_top      = rpa_pkg::TOP_RST;
      req_taken  = 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == rpa_pkg::REG_BASE) m_base = cfg_wdata[rpa_pkg::BASE_W-1:0];
        else m_top = cfg_wdata[rpa_pkg::TOP_W-1:0];
      end
      req_taken = start && !busy;
    end
  end

  // driver: predicts a taken request, then moves on to the next one
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || req_taken) begin
      if (req_taken) due_results.push_back(compute_page_result(in_req));
      if (gap_left != 0 && idle_en) begin
        gap_left--;
        start <= 1'b0;
      end else if (req_q.size() != 0) begin
        in_req <= req_q.pop_front();
        start  <= 1'b1;
        if (idle_en && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 17);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (due_results.size() == 0) begin
        $display("%0t: result with no request pending: expected none, actual %h/%0d",
                 $time, out_res.page_address, out_res.status);
        errors++;
      end else begin
        want = due_results.pop_front();
        if (out_res.page_address !== want.page_address) begin
          $display("%0t: page_address expected %h actual %h",
                   $time, want.page_address, out_res.page_address);
          errors++;
        end
        if (out_res.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_res.status);
          errors++;
        end
      end
    end
  end

  task automatic queue_req(logic [1:0] f, logic [31:0] a);
    rpa_pkg::req_t rq;
    rq.func    = f;
    rq.address = a;
    req_q.push_back(rq);
  endtask

  task automatic wait_drained();
    while (req_q.size() != 0 || start || due_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [rpa_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic program_range(logic [rpa_pkg::CFG_W-1:0] b, logic [rpa_pkg::CFG_W-1:0] t);
    longint unsigned bb, tt;
    wait_drained();
    write_reg(rpa_pkg::REG_BASE, b);
    write_reg(rpa_pkg::REG_TOP, t);
    bb = b[rpa_pkg::BASE_W-1:0];
    tt = t[rpa_pkg::TOP_W-1:0];
    gen_base = bb;
    gen_lim  = (tt < bb + POOL_PAGES) ? tt : bb + POOL_PAGES;
  endtask

  // mostly aligned pages near the top of the range, where allocs land first
  task automatic queue_random(int n, int alloc_pct, bit allow_init);
    int              r;
    longint unsigned hi, lo, pg;
    logic [31:0]     a;
    logic [1:0]      f;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (allow_init && $urandom_range(0, 79) == 0) f = rpa_pkg::FN_INIT;
      else if (r < alloc_pct) f = rpa_pkg::FN_ALLOC;
      else if (r < alloc_pct + (100 - alloc_pct) / 2) f = rpa_pkg::FN_FREE;
      else f = rpa_pkg::FN_SHARE;
      hi = (gen_lim > ADDR_PAGES) ? ADDR_PAGES : gen_lim;
      r  = $urandom_range(0, 99);
      if (f == rpa_pkg::FN_ALLOC || f == rpa_pkg::FN_INIT || r < 8 || hi <= gen_base) begin
        a = $urandom();
      end else begin
        lo = (hi - gen_base > 16) ? hi - 16 : gen_base;
        if (r < 70) pg = lo + $urandom_range(0, int'(hi - lo - 1));
        else if (r < 85) pg = gen_base + $urandom_range(0, int'(hi - gen_base - 1));
        else if (r < 90) pg = gen_base - 1;
        else if (r < 95) pg = hi;
        else pg = lo;
        a = 32'(pg << PG_SHIFT);
        if (r >= 95) a[PG_SHIFT-1:0] = PG_SHIFT'($urandom_range(1, (1 << PG_SHIFT) - 1));
      end
      queue_req(f, a);
    end
  endtask

  initial begin
    gen_base = rpa_pkg::BASE_RST;
    gen_lim  = rpa_pkg::TOP_RST;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // reset range: highest page first, sharing, double free, bad addresses
    queue_req(rpa_pkg::FN_INIT,  32'h0);
    queue_req(rpa_pkg::FN_ALLOC, 32'h0);
    queue_req(rpa_pkg::FN_ALLOC, 32'h0);
    queue_req(rpa_pkg::FN_SHARE, 32'h87FF_F000);
    queue_req(rpa_pkg::FN_FREE,  32'h87FF_F000);
    queue_req(rpa_pkg::FN_FREE,  32'h87FF_F000);
    queue_req(rpa_pkg::FN_FREE,  32'h87FF_F000);
    queue_req(rpa_pkg::FN_SHARE, 32'h87FF_F000);
    queue_req(rpa_pkg::FN_FREE,  32'h87FF_E001);
    queue_req(rpa_pkg::FN_FREE,  32'h7FFF_F000);
    queue_req(rpa_pkg::FN_SHARE, 32'h8800_0000);
    queue_req(rpa_pkg::FN_FREE,  32'h8000_0000);
    queue_req(rpa_pkg::FN_FREE,  32'hFFFF_FFFF);
    queue_req(rpa_pkg::FN_SHARE, 32'h0000_0000);
    queue_req(rpa_pkg::FN_ALLOC, 32'hFFFF_FFFF);
    queue_req(rpa_pkg::FN_FREE,  32'h87FF_E000);
    queue_req(rpa_pkg::FN_FREE,  32'h87FF_F000);

    // empty ranges, including top below base
    program_range(0, 0);
    queue_req(rpa_pkg::FN_INIT,  32'h0);
    queue_req(rpa_pkg::FN_ALLOC, 32'h0);
    queue_req(rpa_pkg::FN_FREE,  32'h0);
    queue_req(rpa_pkg::FN_SHARE, 32'h1000);
    program_range(10, 5);
    queue_req(rpa_pkg::FN_INIT,  32'h0);
    queue_req(rpa_pkg::FN_ALLOC, 32'h0);
    queue_req(rpa_pkg::FN_FREE,  32'h5000);

    // single top page: drive its count up to the limit
    program_range(21'd1048575, 21'd1048576);
    queue_req(rpa_pkg::FN_INIT,  32'h0);
    queue_req(rpa_pkg::FN_ALLOC, 32'h0);
    repeat (260) queue_req(rpa_pkg::FN_SHARE, 32'hFFFF_F000);
    queue_random(40, 20, 1'b0);

    // small pool, with a full drain half way
    program_range(1000, 1016);
    queue_req(rpa_pkg::FN_INIT, 32'h0);
    queue_random(50, 40, 1'b1);
    wait_drained();
    queue_random(50, 35, 1'b1);

    // base moved without a fresh init
    program_range(1004, 1016);
    queue_random(50, 35, 1'b0);

    // top beyond the addressable space: page addresses wrap
    program_range(1040000, 21'h1F_FFFF);
    queue_req(rpa_pkg::FN_INIT, 32'h0);
    queue_random(60, 70, 1'b0);

    // widest pool from page zero
    program_range(0, 21'd1048576);
    queue_req(rpa_pkg::FN_INIT, 32'h0);
    queue_random(60, 40, 1'b0);

    // back to back to the end
    program_range(5, 12);
    idle_en = 1'b0;
    queue_req(rpa_pkg::FN_INIT, 32'h0);
    queue_random(80, 40, 1'b1);

    wait_drained();
    repeat (20) @(negedge clk);
    if (errors == 0 && due_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/rpa_pkg.sv
rtl/rpa_ctrl.sv
rtl/rpa_dpath.sv
rtl/refcounted_page_allocator_core.sv
tb/refcounted_page_allocator_core_tb.sv
